@@ design/stereo_frame_ring_with_tick_admission_macros.svh @@
// Assertion helpers for the stereo frame ring.
`ifndef STEREO_FRAME_RING_WITH_TICK_ADMISSION_MACROS_SVH
`define STEREO_FRAME_RING_WITH_TICK_ADMISSION_MACROS_SVH

// Same-cycle implication.
`define SFRTA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define SFRTA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ design/srfr_pkg.sv @@
package srfr_pkg;

   localparam int TICK_W      = 13;
   localparam int RAW_W       = 32;
   localparam int SMP_W       = 16;
   localparam int PULL_W      = 7;
   localparam int STATUS_W    = 3;
   localparam int AVAIL_W     = 13;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_WRITE = 2'd1,
      OP_PULL  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_NO_ROOM  = 3'd1,
      ST_BAD_LEN  = 3'd2,
      ST_NO_BLOCK = 3'd3,
      ST_OPEN     = 3'd4,
      ST_EMPTY    = 3'd5
   } status_type;

   typedef struct packed {
      op_type                   op;
      logic                     bad_len;
      logic [TICK_W-1:0]        tick_length;
      logic [SMP_W-1:0]         left;
      logic [SMP_W-1:0]         right;
      logic [PULL_W-1:0]        want;
   } cmd_type;

   function automatic logic [SMP_W-1:0] sat16(input logic [RAW_W-1:0] x);
      logic [SMP_W-1:0] r;
      if (x[RAW_W-1] && !(&x[RAW_W-2:SMP_W-1])) begin
         r = 16'h8000;
      end else if (!x[RAW_W-1] && (|x[RAW_W-2:SMP_W-1])) begin
         r = 16'h7fff;
      end else begin
         r = x[SMP_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ design/srfr_front.sv @@
module srfr_front #(
   parameter int CAPACITY = 4096,
   parameter int MAX_PULL = 64
) (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_op,
   input  logic [12:0]              req_tick_length,
   input  logic signed [31:0]       req_left_in,
   input  logic signed [31:0]       req_right_in,
   input  logic [6:0]               req_pull_count,
   input  logic                     q_full,
   output logic                     q_push,
   output srfr_pkg::cmd_type        q_cmd
);
   import srfr_pkg::*;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_cmd.op          = op_type'(req_op);
      q_cmd.bad_len     = (req_tick_length == '0) || (32'(req_tick_length) > CAPACITY);
      q_cmd.tick_length = req_tick_length;
      q_cmd.left        = sat16(req_left_in);
      q_cmd.right       = sat16(req_right_in);
      if (32'(req_pull_count) > MAX_PULL) begin
         q_cmd.want = PULL_W'(MAX_PULL);
      end else begin
         q_cmd.want = req_pull_count;
      end
   end

endmodule

@@ design/srfr_queue.sv @@
module srfr_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  srfr_pkg::cmd_type            push_cmd,
   output logic                         full,
   input  logic                         pop,
   output logic                         empty,
   output srfr_pkg::cmd_type            head_cmd,
   output logic [srfr_pkg::QLVL_W-1:0]  level
);
   import srfr_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0]   level_ff, level_in;

   assign full     = (level_ff == QLVL_W'(QUEUE_DEPTH));
   assign empty    = (level_ff == '0);
   assign level    = level_ff;
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ design/srfr_back.sv @@
module srfr_back #(
   parameter int CAPACITY = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  srfr_pkg::cmd_type     q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic signed [15:0]    rsp_left_out,
   output logic signed [15:0]    rsp_right_out,
   output logic                  rsp_last,
   output logic [12:0]           rsp_available
);
   import srfr_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT} state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]    wa_ff, wa_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                open_ff, open_in;
   logic [CNT_W-1:0]    offset_ff, offset_in;
   logic [CNT_W-1:0]    length_ff, length_in;
   logic [PULL_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]    avail_after_ff, avail_after_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [SMP_W-1:0]    left_ff, left_in;
   logic [SMP_W-1:0]    right_ff, right_in;
   logic                last_ff, last_in;
   logic [AVAIL_W-1:0]  avail_ff, avail_in;

   logic [2*SMP_W-1:0]  mem [CAPACITY];
   logic [2*SMP_W-1:0]  rd_data_ff;
   logic                mem_we;
   logic                mem_re;

   logic                out_free;
   logic [CNT_W-1:0]    free_cnt;
   logic [CNT_W-1:0]    commit_cnt;
   logic [CNT_W-1:0]    offset_inc;
   logic [PULL_W-1:0]   pull_n;
   logic [IDX_W-1:0]    wa_inc;
   logic [IDX_W-1:0]    rd_inc;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_left_out  = left_ff;
   assign rsp_right_out = right_ff;
   assign rsp_last      = last_ff;
   assign rsp_available = avail_ff;

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_ready;
      free_cnt   = CNT_W'(CAPACITY) - count_ff;
      commit_cnt = count_ff + length_ff;
      offset_inc = offset_ff + 1'b1;
      pull_n     = (32'(q_head.want) < 32'(count_ff)) ? q_head.want : PULL_W'(count_ff);
      wa_inc     = (wa_ff == IDX_W'(CAPACITY - 1)) ? '0 : wa_ff + 1'b1;
      rd_inc     = (rd_idx_ff == IDX_W'(CAPACITY - 1)) ? '0 : rd_idx_ff + 1'b1;

      state_in       = state_ff;
      count_in       = count_ff;
      wr_idx_in      = wr_idx_ff;
      wa_in          = wa_ff;
      rd_idx_in      = rd_idx_ff;
      open_in        = open_ff;
      offset_in      = offset_ff;
      length_in      = length_ff;
      rem_in         = rem_ff;
      avail_after_in = avail_after_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      status_in      = status_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      last_in        = last_ff;
      avail_in       = avail_ff;
      q_pop          = 1'b0;
      mem_we         = 1'b0;
      mem_re         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop        = 1'b1;
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               left_in      = '0;
               right_in     = '0;
               last_in      = 1'b1;
               avail_in     = AVAIL_W'(count_ff);
               case (q_head.op)
                  OP_BEGIN: begin
                     if (open_ff) begin
                        status_in = ST_OPEN;
                     end else if (q_head.bad_len) begin
                        status_in = ST_BAD_LEN;
                     end else if (32'(free_cnt) < 32'(q_head.tick_length)) begin
                        status_in = ST_NO_ROOM;
                     end else begin
                        open_in   = 1'b1;
                        length_in = CNT_W'(q_head.tick_length);
                        offset_in = '0;
                        wa_in     = wr_idx_ff;
                     end
                  end
                  OP_WRITE: begin
                     if (!open_ff) begin
                        status_in = ST_NO_BLOCK;
                     end else begin
                        mem_we    = 1'b1;
                        wa_in     = wa_inc;
                        offset_in = offset_inc;
                        if (offset_inc == length_ff) begin
                           count_in  = commit_cnt;
                           wr_idx_in = wa_inc;
                           open_in   = 1'b0;
                           offset_in = '0;
                           length_in = '0;
                           avail_in  = AVAIL_W'(commit_cnt);
                        end
                     end
                  end
                  OP_PULL: begin
                     if (pull_n == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rsp_valid_in   = rsp_valid_ff && !rsp_ready;
                        status_in      = status_ff;
                        left_in        = left_ff;
                        right_in       = right_ff;
                        last_in        = last_ff;
                        avail_in       = avail_ff;
                        count_in       = count_ff - CNT_W'(pull_n);
                        avail_after_in = count_ff - CNT_W'(pull_n);
                        rem_in         = pull_n;
                        state_in       = S_READ;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_READ: begin
            mem_re    = 1'b1;
            rd_idx_in = rd_inc;
            rem_in    = rem_ff - 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               left_in      = rd_data_ff[SMP_W-1:0];
               right_in     = rd_data_ff[2*SMP_W-1:SMP_W];
               last_in      = (rem_ff == '0);
               avail_in     = AVAIL_W'(avail_after_ff);
               state_in     = (rem_ff == '0) ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wr_idx_ff    <= '0;
         wa_ff        <= '0;
         rd_idx_ff    <= '0;
         open_ff      <= 1'b0;
         offset_ff    <= '0;
         length_ff    <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wr_idx_ff    <= wr_idx_in;
         wa_ff        <= wa_in;
         rd_idx_ff    <= rd_idx_in;
         open_ff      <= open_in;
         offset_ff    <= offset_in;
         length_ff    <= length_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      avail_after_ff <= avail_after_in;
      status_ff      <= status_in;
      left_ff        <= left_in;
      right_ff       <= right_in;
      last_ff        <= last_in;
      avail_ff       <= avail_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wa_ff] <= {q_head.right, q_head.left};
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

endmodule

@@ design/stereo_frame_ring_with_tick_admission.sv @@
// Ring of CAPACITY stereo frames with whole-block admission. Items enter a two-entry command
// queue at up to one per cycle while it has room; req_ready drops once both entries are taken,
// as when a result waits on rsp or a pull is being read out. The execution side takes one
// queued item per cycle while rsp is free and no pull runs: begin, write and unused-op items
// each give one beat, registered in the cycle after they are accepted. A pull of n frames
// holds the execution side: S_IDLE takes the item, then per frame S_READ does a registered
// read of the single frame memory and S_EMIT loads the result register; receiver stalls add
// to this. Frame samples are saturated to 16 bits on entry. The frame memory is not cleared
// after reset and needs no clearing pass; only committed, hence written, frames are read.
`include "stereo_frame_ring_with_tick_admission_macros.svh"

module stereo_frame_ring_with_tick_admission #(
   parameter int CAPACITY = 4096,
   parameter int MAX_PULL = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [12:0]         req_tick_length,
   input  logic signed [31:0]  req_left_in,
   input  logic signed [31:0]  req_right_in,
   input  logic [6:0]          req_pull_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_status,
   output logic signed [15:0]  rsp_left_out,
   output logic signed [15:0]  rsp_right_out,
   output logic                rsp_last,
   output logic [12:0]         rsp_available
);
   import srfr_pkg::*;

   cmd_type             push_cmd;
   cmd_type             head_cmd;
   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;
   logic [QLVL_W-1:0]   q_level;

   srfr_front #(
      .CAPACITY (CAPACITY),
      .MAX_PULL (MAX_PULL)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_tick_length (req_tick_length),
      .req_left_in     (req_left_in),
      .req_right_in    (req_right_in),
      .req_pull_count  (req_pull_count),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   srfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_cmd (head_cmd),
      .level    (q_level)
   );

   srfr_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (head_cmd),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .rsp_last      (rsp_last),
      .rsp_available (rsp_available)
   );

   `SFRTA_ASSERT_IMP(a_err_is_last, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_last)
   `SFRTA_ASSERT_IMP(a_empty_zero, clock, reset, rsp_valid && rsp_status == ST_EMPTY,
                     rsp_left_out == 16'sd0 && rsp_right_out == 16'sd0)
   `SFRTA_ASSERT_NXT(a_push_lands, clock, reset, req_valid && req_ready && q_level == '0,
                     q_level != '0)

endmodule
